[rtl/capture_silence_then_fade_in_assert.svh]
// assertion macros for the capture fade-in block
// each use stands on a line of its own in the asserting module
`ifndef CAPTURE_SILENCE_THEN_FADE_IN_ASSERT_SVH
`define CAPTURE_SILENCE_THEN_FADE_IN_ASSERT_SVH

// same-cycle implication, off while reset is held
`define CSFI_ASSERT_NOW(label, clk, rstn, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication, off while reset is held
`define CSFI_ASSERT_NEXT(label, clk, rstn, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
        else $error(msg);

`endif

[rtl/csfi_pkg.sv]
// ----------------------------------------------------------------------------
// csfi_pkg
// shared widths, register indices, reset values and phase codes of the
// capture silence / fade-in block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package csfi_pkg;

    // payload and configuration widths
    localparam int unsigned CSFI_SAMPLE_W = 32;
    localparam int unsigned CSFI_PHASE_W  = 2;
    localparam int unsigned CSFI_CFG_W    = 20;
    localparam int unsigned CSFI_IDX_W    = 3;
    localparam int unsigned CSFI_FRM_W    = 13;
    localparam int unsigned CSFI_CHN_W    = 4;
    localparam int unsigned CSFI_BLK_W    = 8;
    localparam int unsigned CSFI_BIDX_W   = 9;

    // default sizing
    localparam int unsigned CSFI_MAX_CHANNELS = 8;
    localparam int unsigned CSFI_MAX_FRAMES   = 4096;

    // register indices
    localparam logic [CSFI_IDX_W-1:0] CSFI_REG_FRAMES  = 3'd0;
    localparam logic [CSFI_IDX_W-1:0] CSFI_REG_CHANS   = 3'd1;
    localparam logic [CSFI_IDX_W-1:0] CSFI_REG_SILENCE = 3'd2;
    localparam logic [CSFI_IDX_W-1:0] CSFI_REG_RAMP    = 3'd3;
    localparam logic [CSFI_IDX_W-1:0] CSFI_REG_GAIN    = 3'd4;

    // register reset values
    localparam logic [CSFI_FRM_W-1:0] CSFI_FRAMES_RST  = 13'd256;
    localparam logic [CSFI_CHN_W-1:0] CSFI_CHANS_RST   = 4'd2;
    localparam logic [CSFI_BLK_W-1:0] CSFI_SILENCE_RST = 8'd0;
    localparam logic [CSFI_BLK_W-1:0] CSFI_RAMP_RST    = 8'd0;
    localparam logic [CSFI_CFG_W-1:0] CSFI_GAIN_RST    = 20'd0;

    // phase codes on the result channel
    localparam logic [CSFI_PHASE_W-1:0] CSFI_PHASE_SILENCE = 2'd0;
    localparam logic [CSFI_PHASE_W-1:0] CSFI_PHASE_RAMP    = 2'd1;
    localparam logic [CSFI_PHASE_W-1:0] CSFI_PHASE_PASS    = 2'd2;

endpackage : csfi_pkg

`default_nettype wire

[rtl/capture_silence_then_fade_in.sv]
// ----------------------------------------------------------------------------
// capture_silence_then_fade_in
// mutes the first capture blocks, fades in the next ones, then passes through
// silence and pass-through samples go through the result and output registers; ramp samples
//   first pass the prep, 32-step serial divide, multiply and sign-fix states
// one sample at a time: no new sample is taken until the last result is in the output register
// reset: synchronous active-low aresetn restores register defaults, no sweep
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "capture_silence_then_fade_in_assert.svh"

module capture_silence_then_fade_in
    import csfi_pkg::*;
#(
    parameter int unsigned MAX_CHANNELS = CSFI_MAX_CHANNELS,
    parameter int unsigned MAX_FRAMES   = CSFI_MAX_FRAMES
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // configuration write port
    input  wire logic                            cfg_we,
    input  wire logic [CSFI_IDX_W-1:0]           cfg_index,
    input  wire logic [CSFI_CFG_W-1:0]           cfg_wdata,
    // input sample channel
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic signed [CSFI_SAMPLE_W-1:0] s_sample_in,
    // result channel
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic signed [CSFI_SAMPLE_W-1:0]      m_sample_out,
    output logic [CSFI_PHASE_W-1:0]              m_phase
);

    // ------------------------------------------------------------------------
    // derived widths
    // ------------------------------------------------------------------------
    // effective frame / channel counts reach the maxima themselves
    localparam int unsigned FRAMES_W = $clog2(MAX_FRAMES + 1);
    localparam int unsigned CHANS_W  = $clog2(MAX_CHANNELS + 1);
    // positions stay below the maxima
    localparam int unsigned FPOS_W   = $clog2(MAX_FRAMES);
    localparam int unsigned CPOS_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    // divisor is frames times ramp blocks
    localparam int unsigned DVS_W    = FRAMES_W + CSFI_BLK_W;
    localparam int unsigned CNT_W    = $clog2(CSFI_SAMPLE_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CSFI_SAMPLE_W - 1);

    // sequencer states
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_PREP = 3'd1;
    localparam logic [2:0] ST_DIV  = 3'd2;
    localparam logic [2:0] ST_MUL  = 3'd3;
    localparam logic [2:0] ST_FIX  = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;

    // ------------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------------
    logic [CSFI_FRM_W-1:0]  frames_cfg_reg;
    logic [CSFI_CHN_W-1:0]  chans_cfg_reg;
    logic [CSFI_BLK_W-1:0]  silence_reg;
    logic [CSFI_BLK_W-1:0]  ramp_blk_reg;

    // ------------------------------------------------------------------------
    // stream position state
    // ------------------------------------------------------------------------
    logic [CSFI_BIDX_W-1:0]   block_index_reg, block_index_next;
    logic [CSFI_SAMPLE_W-1:0] ramp_gain_reg, ramp_gain_next;
    logic [FPOS_W-1:0]        frame_pos_reg, frame_pos_next;
    logic [CPOS_W-1:0]        chan_pos_reg, chan_pos_next;

    // ------------------------------------------------------------------------
    // sequencer and datapath registers
    // ------------------------------------------------------------------------
    logic [2:0]               state_reg;
    logic [CSFI_SAMPLE_W-1:0] sample_reg;     // sample under work
    logic [CSFI_SAMPLE_W-1:0] gain_reg;       // gain captured for this sample
    logic                     neg_reg;        // sample was negative
    logic [DVS_W-1:0]         divisor_reg;
    logic [DVS_W-1:0]         rem_reg;        // partial remainder
    logic [CSFI_SAMPLE_W-1:0] dvd_reg;        // dividend out, quotient in
    logic [CNT_W-1:0]         cnt_reg;
    logic [CSFI_SAMPLE_W-1:0] prod_reg;
    logic [CSFI_SAMPLE_W-1:0] res_sample_reg; // finished result awaiting the output
    logic [CSFI_PHASE_W-1:0]  res_phase_reg;

    // output register
    logic                     m_valid_reg;
    logic signed [CSFI_SAMPLE_W-1:0] m_sample_reg;
    logic [CSFI_PHASE_W-1:0]  m_phase_reg;

    // ------------------------------------------------------------------------
    // effective sizes: zero taken as one, clamp to the maxima
    // ------------------------------------------------------------------------
    logic [FRAMES_W-1:0]    eff_frames;
    logic [CHANS_W-1:0]     eff_chans;

    always_comb begin
        if (frames_cfg_reg == '0) begin
            eff_frames = FRAMES_W'(1);
        end else if (32'(frames_cfg_reg) > 32'(MAX_FRAMES)) begin
            eff_frames = FRAMES_W'(MAX_FRAMES);
        end else begin
            eff_frames = FRAMES_W'(32'(frames_cfg_reg));
        end
    end

    always_comb begin
        if (chans_cfg_reg == '0) begin
            eff_chans = CHANS_W'(1);
        end else if (32'(chans_cfg_reg) > 32'(MAX_CHANNELS)) begin
            eff_chans = CHANS_W'(MAX_CHANNELS);
        end else begin
            eff_chans = CHANS_W'(32'(chans_cfg_reg));
        end
    end

    // ------------------------------------------------------------------------
    // phase decision and position bookkeeping
    // ------------------------------------------------------------------------
    logic [CSFI_BIDX_W-1:0] total_blocks;
    logic                   in_silence;
    logic                   in_ramp;
    logic                   chan_wrap;
    logic                   frame_wrap;
    logic                   accept;

    assign total_blocks = CSFI_BIDX_W'(silence_reg) + CSFI_BIDX_W'(ramp_blk_reg);
    assign in_silence   = block_index_reg < CSFI_BIDX_W'(silence_reg);
    assign in_ramp      = !in_silence && (block_index_reg < total_blocks);
    // a position at or past a reduced size wraps at the next boundary
    assign chan_wrap    = (32'(chan_pos_reg) + 32'd1) >= 32'(eff_chans);
    assign frame_wrap   = (32'(frame_pos_reg) + 32'd1) >= 32'(eff_frames);
    assign accept       = s_valid && s_ready;

    always_comb begin
        block_index_next = block_index_reg;
        ramp_gain_next   = ramp_gain_reg;
        frame_pos_next   = frame_pos_reg;
        chan_pos_next    = chan_pos_reg;
        if (accept) begin
            if (chan_wrap) begin
                chan_pos_next = '0;
                // gain steps once per ramp frame
                if (in_ramp) begin
                    ramp_gain_next = ramp_gain_reg + CSFI_SAMPLE_W'(1);
                end
                if (frame_wrap) begin
                    frame_pos_next = '0;
                    // block counter saturates at the end of the ramp
                    if (block_index_reg < total_blocks) begin
                        block_index_next = block_index_reg + CSFI_BIDX_W'(1);
                    end
                end else begin
                    frame_pos_next = frame_pos_reg + FPOS_W'(1);
                end
            end else begin
                chan_pos_next = chan_pos_reg + CPOS_W'(1);
            end
        end
        // a start gain write reloads the running gain
        if (cfg_we && (cfg_index == CSFI_REG_GAIN)) begin
            ramp_gain_next = CSFI_SAMPLE_W'(cfg_wdata);
        end
    end

    // configuration writes and position state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frames_cfg_reg  <= CSFI_FRAMES_RST;
            chans_cfg_reg   <= CSFI_CHANS_RST;
            silence_reg     <= CSFI_SILENCE_RST;
            ramp_blk_reg    <= CSFI_RAMP_RST;
            block_index_reg <= '0;
            ramp_gain_reg   <= CSFI_SAMPLE_W'(CSFI_GAIN_RST);
            frame_pos_reg   <= '0;
            chan_pos_reg    <= '0;
        end else begin
            block_index_reg <= block_index_next;
            ramp_gain_reg   <= ramp_gain_next;
            frame_pos_reg   <= frame_pos_next;
            chan_pos_reg    <= chan_pos_next;
            if (cfg_we) begin
                case (cfg_index)
                    CSFI_REG_FRAMES:  frames_cfg_reg <= cfg_wdata[CSFI_FRM_W-1:0];
                    CSFI_REG_CHANS:   chans_cfg_reg  <= cfg_wdata[CSFI_CHN_W-1:0];
                    CSFI_REG_SILENCE: silence_reg    <= cfg_wdata[CSFI_BLK_W-1:0];
                    CSFI_REG_RAMP:    ramp_blk_reg   <= cfg_wdata[CSFI_BLK_W-1:0];
                    // start gain handled with the running gain above
                    default: ;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // shared unit: one restoring divide step per cycle
    // ------------------------------------------------------------------------
    logic [DVS_W:0]           div_shift;
    logic [DVS_W+1:0]         div_diff;
    logic                     div_take;
    logic [CSFI_SAMPLE_W-1:0] mul_lo;
    logic                     out_free;
    logic                     out_load;

    assign div_shift = {rem_reg, dvd_reg[CSFI_SAMPLE_W-1]};
    assign div_diff  = {1'b0, div_shift} - {2'b00, divisor_reg};
    assign div_take  = !div_diff[DVS_W+1];
    // only the low word of the product is kept, so it wraps as required
    assign mul_lo    = dvd_reg * gain_reg;
    // output register empty or being emptied this cycle
    assign out_free  = !m_valid_reg || m_ready;
    // finished result moves into the output register
    assign out_load  = (state_reg == ST_OUT) && out_free;

    // ------------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            cnt_reg     <= '0;
        end else begin
            // result taken and nothing new to load
            if (m_ready && (state_reg != ST_OUT)) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        sample_reg <= s_sample_in;
                        gain_reg   <= ramp_gain_reg;
                        if (in_silence) begin
                            res_sample_reg <= '0;
                            res_phase_reg  <= CSFI_PHASE_SILENCE;
                            state_reg      <= ST_OUT;
                        end else if (in_ramp) begin
                            res_phase_reg  <= CSFI_PHASE_RAMP;
                            state_reg      <= ST_PREP;
                        end else begin
                            res_sample_reg <= s_sample_in;
                            res_phase_reg  <= CSFI_PHASE_PASS;
                            state_reg      <= ST_OUT;
                        end
                    end
                end
                ST_PREP: begin
                    // divisor and magnitude of the dividend
                    divisor_reg <= DVS_W'(eff_frames) * DVS_W'(ramp_blk_reg);
                    neg_reg     <= sample_reg[CSFI_SAMPLE_W-1];
                    dvd_reg     <= sample_reg[CSFI_SAMPLE_W-1]
                                   ? (~sample_reg + CSFI_SAMPLE_W'(1)) : sample_reg;
                    rem_reg     <= '0;
                    cnt_reg     <= '0;
                    state_reg   <= ST_DIV;
                end
                ST_DIV: begin
                    rem_reg <= div_take ? div_diff[DVS_W-1:0] : div_shift[DVS_W-1:0];
                    dvd_reg <= {dvd_reg[CSFI_SAMPLE_W-2:0], div_take};
                    cnt_reg <= cnt_reg + CNT_W'(1);
                    if (cnt_reg == CNT_LAST) begin
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    // magnitude quotient times gain
                    prod_reg  <= mul_lo;
                    state_reg <= ST_FIX;
                end
                ST_FIX: begin
                    // truncating division: sign follows the sample
                    res_sample_reg <= neg_reg ? (~prod_reg + CSFI_SAMPLE_W'(1)) : prod_reg;
                    state_reg      <= ST_OUT;
                end
                ST_OUT: begin
                    if (out_free) begin
                        m_valid_reg  <= 1'b1;
                        m_sample_reg <= res_sample_reg;
                        m_phase_reg  <= res_phase_reg;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_ready      = (state_reg == ST_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_sample_out = m_sample_reg;
    assign m_phase      = m_phase_reg;

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    logic phase_legal;
    logic muted_out;

    assign phase_legal = m_phase_reg inside {CSFI_PHASE_SILENCE, CSFI_PHASE_RAMP,
                                             CSFI_PHASE_PASS};
    assign muted_out   = m_valid_reg && (m_phase_reg == CSFI_PHASE_SILENCE);

    `CSFI_ASSERT_NOW(a_phase_code, aclk, aresetn, m_valid_reg, phase_legal, "bad phase code")
    `CSFI_ASSERT_NOW(a_silence_zero, aclk, aresetn, muted_out, m_sample_reg == '0, "muted not zero")
    `CSFI_ASSERT_NEXT(a_busy_after_transfer, aclk, aresetn, accept, !s_ready, "idle after transfer")
    `CSFI_ASSERT_NEXT(a_result_loaded, aclk, aresetn, out_load, m_valid_reg && s_ready, "not loaded")

endmodule : capture_silence_then_fade_in

`default_nettype wire

[test/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for capture_silence_then_fade_in: a short table of
// hand-picked register settings and samples, then randomised setups and
// sample streams, every result scored against a hand-written value or an in-bench
// model of the muting, fade-in scaling, pass-through and block counting
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_top;
    import csfi_pkg::*;

    // run shape
    localparam int unsigned PLAN_LEN       = 41;
    localparam int unsigned RANDOM_ITEMS   = 728;
    localparam int unsigned SETTLE_CYCLES  = 40;
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned MAX_REPORTS    = 10;
    localparam int unsigned IDLE_PERCENT   = 25;

    // first index past the defined registers, writes there must be ignored
    localparam logic [CSFI_IDX_W-1:0] REG_UNUSED = CSFI_REG_GAIN + 1'b1;
    localparam int unsigned BLK_MAX   = (1 << CSFI_BLK_W) - 1;
    localparam int unsigned BLOCK_TOP = (1 << CSFI_BIDX_W) - 1;

    typedef logic signed [CSFI_SAMPLE_W-1:0] sample_t;

    typedef struct packed {
        sample_t                  sample;
        logic [CSFI_PHASE_W-1:0]  phase;
    } fade_result_t;

    // one row of the directed table: a register write, a sample scored by
    // the model, or a sample whose result is written out by hand
    typedef enum logic [1:0] {ROW_REG, ROW_SAMPLE, ROW_KNOWN} row_kind_t;

    typedef struct packed {
        row_kind_t               kind;
        logic [CSFI_IDX_W-1:0]   index;
        logic [CSFI_CFG_W-1:0]   value;
        sample_t                 sample;
        fade_result_t            known;
    } plan_row_t;

    // ------------------------------------------------------------------
    // clock, reset and block ports, every input known from time zero
    // ------------------------------------------------------------------
    logic                    aclk        = 1'b0;
    logic                    aresetn     = 1'b0;
    logic                    cfg_we      = 1'b0;
    logic [CSFI_IDX_W-1:0]   cfg_index   = '0;
    logic [CSFI_CFG_W-1:0]   cfg_wdata   = '0;
    logic                    s_valid     = 1'b0;
    logic                    s_ready;
    sample_t                 s_sample_in = '0;
    logic                    m_valid;
    logic                    m_ready     = 1'b0;
    sample_t                 m_sample_out;
    logic [CSFI_PHASE_W-1:0] m_phase;

    always #10 aclk = ~aclk;

    capture_silence_then_fade_in DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_sample_in  (s_sample_in),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_sample_out (m_sample_out),
        .m_phase      (m_phase)
    );

    // ------------------------------------------------------------------
    // model copy of the registers and of the counting state
    // ------------------------------------------------------------------
    logic [CSFI_FRM_W-1:0]  reg_frames  = CSFI_FRAMES_RST;
    logic [CSFI_CHN_W-1:0]  reg_chans   = CSFI_CHANS_RST;
    logic [CSFI_BLK_W-1:0]  reg_silence = CSFI_SILENCE_RST;
    logic [CSFI_BLK_W-1:0]  reg_ramp    = CSFI_RAMP_RST;
    logic [CSFI_CFG_W-1:0]  reg_gain    = CSFI_GAIN_RST;
    logic [CSFI_BIDX_W-1:0] block_idx   = '0;
    logic [31:0]            ramp_gain   = 32'(CSFI_GAIN_RST);
    logic [11:0]            frame_pos   = '0;
    logic [2:0]             chan_pos    = '0;

    fade_result_t awaited[$];       // results still owed by the block
    int unsigned  mismatches = 0;
    int unsigned  quiet_cycles = 0;
    logic         calm = 1'b0;      // set for a stretch with no idling on either side
    plan_row_t    plan [PLAN_LEN];

    // result of one sample and the step of channel, frame and block
    function automatic fade_result_t condition_sample(input sample_t smp);
        int unsigned  frames;
        int unsigned  chans;
        int unsigned  total;
        longint       quot;
        logic [31:0]  quot_lo;
        logic         in_ramp;
        fade_result_t res;
        // zero sizes count as one, oversize ones are clamped
        frames = (reg_frames == 0) ? 1 :
                 (32'(reg_frames) > CSFI_MAX_FRAMES) ? CSFI_MAX_FRAMES : 32'(reg_frames);
        chans  = (reg_chans == 0) ? 1 :
                 (32'(reg_chans) > CSFI_MAX_CHANNELS) ? CSFI_MAX_CHANNELS : 32'(reg_chans);
        total  = 32'(reg_silence) + 32'(reg_ramp);
        in_ramp = 1'b0;
        if (block_idx < CSFI_BIDX_W'(reg_silence)) begin
            res.sample = '0;
            res.phase  = CSFI_PHASE_SILENCE;
        end else if (32'(block_idx) < total) begin
            // ramp count is non-zero here; division truncates toward zero
            quot       = longint'(smp) / (longint'(frames) * longint'(reg_ramp));
            quot_lo    = quot[31:0];
            res.sample = quot_lo * ramp_gain;
            res.phase  = CSFI_PHASE_RAMP;
            in_ramp    = 1'b1;
        end else begin
            res.sample = smp;
            res.phase  = CSFI_PHASE_PASS;
        end
        // a position left past a shrunk size wraps at its next boundary
        if (32'(chan_pos) + 32'd1 >= chans) begin
            chan_pos = '0;
            if (in_ramp) begin
                ramp_gain = ramp_gain + 32'd1;
            end
            if (32'(frame_pos) + 32'd1 >= frames) begin
                frame_pos = '0;
                // the block counter stops once past silence and ramp
                if (32'(block_idx) < total && 32'(block_idx) < BLOCK_TOP) begin
                    block_idx = block_idx + 1'b1;
                end
            end else begin
                frame_pos = frame_pos + 1'b1;
            end
        end else begin
            chan_pos = chan_pos + 1'b1;
        end
        return res;
    endfunction

    function automatic void apply_reg_write(input logic [CSFI_IDX_W-1:0] idx,
                                            input logic [CSFI_CFG_W-1:0] val);
        case (idx)
            CSFI_REG_FRAMES:  reg_frames  = val[CSFI_FRM_W-1:0];
            CSFI_REG_CHANS:   reg_chans   = val[CSFI_CHN_W-1:0];
            CSFI_REG_SILENCE: reg_silence = val[CSFI_BLK_W-1:0];
            CSFI_REG_RAMP:    reg_ramp    = val[CSFI_BLK_W-1:0];
            CSFI_REG_GAIN: begin
                // a new start gain restarts the ramp gain, positions stay
                reg_gain  = val;
                ramp_gain = 32'(val);
            end
            default: ;
        endcase
    endfunction

    function automatic void flag_mismatch(input string what);
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
            $display("[%0t] mismatch: %s", $realtime, what);
        end
    endfunction

    function automatic plan_row_t reg_row(input logic [CSFI_IDX_W-1:0] idx,
                                          input logic [CSFI_CFG_W-1:0] val);
        plan_row_t r;
        r       = '0;
        r.kind  = ROW_REG;
        r.index = idx;
        r.value = val;
        return r;
    endfunction

    function automatic plan_row_t sample_row(input sample_t smp);
        plan_row_t r;
        r        = '0;
        r.kind   = ROW_SAMPLE;
        r.sample = smp;
        return r;
    endfunction

    function automatic plan_row_t known_row(input sample_t smp, input sample_t out,
                                            input logic [CSFI_PHASE_W-1:0] ph);
        plan_row_t r;
        r              = '0;
        r.kind         = ROW_KNOWN;
        r.sample       = smp;
        r.known.sample = out;
        r.known.phase  = ph;
        return r;
    endfunction

    // random sample: mostly full-range, with the extremes and small values
    function automatic sample_t pick_sample();
        case ($urandom_range(0, 9))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'($urandom_range(0, 4095));
            3:       return 32'(0 - $urandom_range(1, 4095));
            default: return 32'($urandom);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // driving tasks, each returns just after a rising edge
    // ------------------------------------------------------------------

    // write enable stays high so back-to-back writes need no re-raise
    task automatic write_reg(input logic [CSFI_IDX_W-1:0] idx,
                             input logic [CSFI_CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        apply_reg_write(idx, val);
    endtask

    // one sample transfer; the hand-written result wins where given
    task automatic send_sample(input sample_t smp, input logic typed,
                               input fade_result_t known);
        fade_result_t predicted;
        cfg_we <= 1'b0;
        if (!calm && $urandom_range(0, 99) < IDLE_PERCENT) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_sample_in <= smp;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predicted = condition_sample(smp);
        awaited.push_back(typed ? known : predicted);
    endtask

    // sender holds off until every owed result is out, then lets the pipe settle
    task automatic wait_for_results();
        s_valid <= 1'b0;
        cfg_we  <= 1'b0;
        while (awaited.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // new setup for a random phase, extremes now and then, otherwise small
    // blocks with silence and ramp placed just ahead of the block counter
    task automatic program_random_setup();
        logic [CSFI_CFG_W-1:0] frames;
        logic [CSFI_CFG_W-1:0] chans;
        logic [CSFI_CFG_W-1:0] silence;
        logic [CSFI_CFG_W-1:0] ramp;
        logic [CSFI_CFG_W-1:0] gain;
        case ($urandom_range(0, 15))
            0:       frames = '0;
            1:       frames = CSFI_CFG_W'(CSFI_MAX_FRAMES);
            2:       frames = CSFI_CFG_W'((1 << CSFI_FRM_W) - 1);
            3:       frames = CSFI_CFG_W'($urandom_range(0, (1 << CSFI_FRM_W) - 1));
            default: frames = CSFI_CFG_W'($urandom_range(1, 4));
        endcase
        case ($urandom_range(0, 15))
            0:       chans = '0;
            1:       chans = CSFI_CFG_W'(CSFI_MAX_CHANNELS);
            2:       chans = CSFI_CFG_W'((1 << CSFI_CHN_W) - 1);
            3:       chans = CSFI_CFG_W'($urandom_range(0, (1 << CSFI_CHN_W) - 1));
            default: chans = CSFI_CFG_W'($urandom_range(1, 3));
        endcase
        case ($urandom_range(0, 15))
            0:       silence = '0;
            1:       silence = CSFI_CFG_W'(BLK_MAX);
            default: begin
                silence = 20'(block_idx) + 20'($urandom_range(0, 2));
                if (32'(silence) > BLK_MAX) begin
                    silence = CSFI_CFG_W'(BLK_MAX);
                end
            end
        endcase
        case ($urandom_range(0, 15))
            0:       ramp = CSFI_CFG_W'(BLK_MAX);
            default: ramp = CSFI_CFG_W'($urandom_range(0, 3));
        endcase
        case ($urandom_range(0, 7))
            0:       gain = '0;
            1:       gain = '1;
            default: gain = CSFI_CFG_W'($urandom_range(0, (1 << CSFI_CFG_W) - 1));
        endcase
        write_reg(CSFI_REG_FRAMES, frames);
        write_reg(CSFI_REG_CHANS, chans);
        write_reg(CSFI_REG_SILENCE, silence);
        write_reg(CSFI_REG_RAMP, ramp);
        write_reg(CSFI_REG_GAIN, gain);
        if ($urandom_range(0, 3) == 0) begin
            write_reg(CSFI_IDX_W'($urandom_range(32'(REG_UNUSED), (1 << CSFI_IDX_W) - 1)),
                      CSFI_CFG_W'($urandom));
        end
    endtask

    // ------------------------------------------------------------------
    // result scoring and receiver back-pressure
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : score_results
        fade_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (awaited.size() == 0) begin
                flag_mismatch($sformatf("unexpected result sample %h phase %0d",
                                        m_sample_out, m_phase));
            end else begin
                want = awaited.pop_front();
                if (m_sample_out !== want.sample) begin
                    flag_mismatch($sformatf("sample expected %h got %h",
                                            want.sample, m_sample_out));
                end
                if (m_phase !== want.phase) begin
                    flag_mismatch($sformatf("phase expected %0d got %0d",
                                            want.phase, m_phase));
                end
            end
        end
        m_ready <= calm || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end

    // watchdog: too long without a transfer on either channel
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", quiet_cycles);
            $display("TEST FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    initial begin : stimulus
        logic        after_sample;
        int unsigned phase_no;
        int unsigned phase_len;
        int unsigned random_sent;

        plan = '{
            // reset setup has no silence and no ramp: straight pass-through
            known_row(32'h7FFF_FFFF, 32'h7FFF_FFFF, CSFI_PHASE_PASS),
            known_row(32'h8000_0000, 32'h8000_0000, CSFI_PHASE_PASS),
            // zero sizes count as one; frame position is left past the new size
            reg_row(CSFI_REG_FRAMES, 20'd0),
            reg_row(CSFI_REG_CHANS, 20'd0),
            reg_row(CSFI_REG_SILENCE, 20'd2),
            known_row(32'hFFFF_FFFF, 32'h0, CSFI_PHASE_SILENCE),
            known_row(32'h1234_5678, 32'h0, CSFI_PHASE_SILENCE),
            // block counter now held at the end of silence
            known_row(32'h5A5A_5A5A, 32'h5A5A_5A5A, CSFI_PHASE_PASS),
            known_row(32'hA5A5_A5A5, 32'hA5A5_A5A5, CSFI_PHASE_PASS),
            // one-frame ramp with divisor one, product wraps
            reg_row(CSFI_REG_RAMP, 20'd1),
            reg_row(CSFI_REG_GAIN, 20'd3),
            reg_row(CSFI_REG_FRAMES, 20'd1),
            reg_row(CSFI_REG_CHANS, 20'd1),
            sample_row(32'h7FFF_FFFF),
            sample_row(32'h0000_0010),
            // oversize frames and channels clamp, largest ramp and gain
            reg_row(CSFI_REG_RAMP, 20'd255),
            reg_row(CSFI_REG_FRAMES, 20'd8191),
            reg_row(CSFI_REG_CHANS, 20'd15),
            reg_row(CSFI_REG_GAIN, 20'hF_FFFF),
            sample_row(32'h7FFF_FFFF),
            sample_row(32'h8000_0000),
            sample_row(32'hFFFF_FFFF),
            sample_row(32'h000F_F000),
            // channel position past a shrunk frame, then frame past one
            reg_row(CSFI_REG_CHANS, 20'd3),
            sample_row(32'h4000_0000),
            reg_row(CSFI_REG_FRAMES, 20'd1),
            sample_row(32'hC000_0000),
            sample_row(32'h3FFF_FFFF),
            sample_row(32'hBFFF_FFFF),
            // start gain rewritten in mid-ramp reloads the gain
            reg_row(CSFI_REG_CHANS, 20'd1),
            reg_row(CSFI_REG_GAIN, 20'd7),
            sample_row(32'h7FFF_FFFF),
            sample_row(32'h8000_0001),
            // longest silence; a write to an unused index changes nothing
            reg_row(CSFI_REG_SILENCE, 20'd255),
            known_row(32'h7FFF_FFFF, 32'h0, CSFI_PHASE_SILENCE),
            reg_row(REG_UNUSED, 20'hF_FFFF),
            known_row(32'h8000_0000, 32'h0, CSFI_PHASE_SILENCE),
            reg_row(CSFI_REG_SILENCE, 20'd0),
            reg_row(CSFI_REG_RAMP, 20'd0),
            known_row(32'h0000_0001, 32'h0000_0001, CSFI_PHASE_PASS),
            known_row(32'hDEAD_BEEF, 32'hDEAD_BEEF, CSFI_PHASE_PASS)
        };

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // directed table, registers only change once the block has gone idle
        after_sample = 1'b0;
        foreach (plan[i]) begin
            case (plan[i].kind)
                ROW_REG: begin
                    if (after_sample) begin
                        wait_for_results();
                    end
                    write_reg(plan[i].index, plan[i].value);
                    after_sample = 1'b0;
                end
                ROW_KNOWN: begin
                    send_sample(plan[i].sample, 1'b1, plan[i].known);
                    after_sample = 1'b1;
                end
                default: begin
                    send_sample(plan[i].sample, 1'b0, plan[i].known);
                    after_sample = 1'b1;
                end
            endcase
        end

        // random phases, each behind a full drain of the block
        phase_no    = 0;
        random_sent = 0;
        while (random_sent < RANDOM_ITEMS) begin
            wait_for_results();
            calm = (phase_no >= 3 && phase_no <= 5);
            program_random_setup();
            phase_len = $urandom_range(10, 50);
            repeat (phase_len) begin
                send_sample(pick_sample(), 1'b0, '0);
            end
            random_sent += phase_len;
            phase_no++;
        end

        wait_for_results();
        if (mismatches == 0 && awaited.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl
rtl/csfi_pkg.sv
rtl/capture_silence_then_fade_in.sv
test/tb_top.sv
